// File: rtl/sars_pkg.sv
// Shared constants and types for the stepper acceleration ramp step block.
`timescale 1ns / 1ps
`default_nettype none
package sars_pkg;

    // Field widths
    localparam int INTERVAL_W = 32;
    localparam int SPEED_W    = 24;
    localparam int ACCEL_W    = 20;
    localparam int RAMP_W     = 32;
    localparam int CFG_IDX_W  = 2;

    // Serial datapath widths
    localparam int SQ_W   = 2 * SPEED_W;  // speed squared
    localparam int NUM_W  = 36;           // divider dividend
    localparam int DEN_W  = 33;           // divider divisor and remainder
    localparam int CNT_W  = 6;            // iteration counter

    // Bit counts for each serial pass
    localparam logic [CNT_W-1:0] MUL_BITS   = 6'd24;
    localparam logic [CNT_W-1:0] STOP_BITS  = 6'd31;
    localparam logic [CNT_W-1:0] STEP_BITS  = 6'd33;
    localparam logic [CNT_W-1:0] SPEED_BITS = 6'd36;

    // 1e6 us times Q8 times Q8 speed scale
    localparam logic [NUM_W-1:0]      SPEED_NUM = 36'hF42400000;
    localparam logic [SPEED_W-1:0]    SPEED_MAX = 24'hFFFFFF;
    localparam logic [RAMP_W-1:0]     RAMP_MAX  = 32'h7FFFFFFF;
    localparam logic [RAMP_W-1:0]     RAMP_MIN  = 32'h80000000;

    // Register reset values
    localparam logic [INTERVAL_W-1:0] MIN_INTERVAL_RST   = 32'd256000;
    localparam logic [INTERVAL_W-1:0] FIRST_INTERVAL_RST = 32'd256000;
    localparam logic [ACCEL_W-1:0]    ACCEL_RST          = 20'd1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_INTERVAL   = 2'd0,
        CFG_FIRST_INTERVAL = 2'd1,
        CFG_ACCEL          = 2'd2
    } t_cfg_idx;

endpackage
`default_nettype wire

// File: rtl/stepper_accel_ramp_step.sv
// Stepper linear-acceleration ramp: one step event in, one interval word out.
//
//  channel   direction  handshake                       payload
//  input     in         i_in_valid / o_in_stall         i_distance_to_go
//  result    out        o_out_valid / i_out_stall       o_interval_q8, o_speed_q8,
//                                                       o_move_cw, o_stopped, o_ramp_index
//  config    in         i_cfg_valid / o_cfg_ready       i_cfg_index, i_cfg_data
//
// One word at a time through a bit-serial shift-add multiplier and
// one shared restoring divider that retires one quotient bit per cycle.
// A ramp step runs multiply, stop divide, recurrence divide and speed divide;
// a stop ends after the stop divide and a first step skips the recurrence divide.
// The result sits in an output register, so o_in_stall drops as soon as it is
// loaded; a stalled result holds the engine in its last state until taken.
// Synchronous active-low reset returns control, ramp state and config registers to their reset values.
`timescale 1ns / 1ps
`default_nettype none
module stepper_accel_ramp_step (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    // input word
    input  wire logic                                   i_in_valid,
    output logic                                        o_in_stall,
    input  wire logic signed [sars_pkg::RAMP_W-1:0]     i_distance_to_go,
    // result word
    output logic                                        o_out_valid,
    input  wire logic                                   i_out_stall,
    output logic [sars_pkg::INTERVAL_W-1:0]             o_interval_q8,
    output logic [sars_pkg::SPEED_W-1:0]                o_speed_q8,
    output logic                                        o_move_cw,
    output logic                                        o_stopped,
    output logic signed [sars_pkg::RAMP_W-1:0]          o_ramp_index,
    // configuration writes
    input  wire logic                                   i_cfg_valid,
    output logic                                        o_cfg_ready,
    input  wire logic [sars_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [sars_pkg::INTERVAL_W-1:0]        i_cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV_STOP,
        ST_STEP_LOAD,
        ST_DIV_STEP,
        ST_DIV_SPEED,
        ST_FINISH
    } t_state;

    t_state r_state;

    // config registers
    logic [sars_pkg::INTERVAL_W-1:0] r_min_interval;
    logic [sars_pkg::INTERVAL_W-1:0] r_first_interval;
    logic [sars_pkg::ACCEL_W-1:0]    r_accel;

    // ramp state
    logic [sars_pkg::RAMP_W-1:0]     r_ramp;
    logic [sars_pkg::INTERVAL_W-1:0] r_interval;
    logic [sars_pkg::SPEED_W-1:0]    r_speed;
    logic                            r_dir;
    logic                            r_stopped;
    logic [sars_pkg::RAMP_W-1:0]     r_d;

    // serial datapath
    logic [sars_pkg::SQ_W-1:0]       r_acc;
    logic [sars_pkg::SPEED_W-1:0]    r_mplr;
    logic [sars_pkg::NUM_W-1:0]      r_num;
    logic [sars_pkg::DEN_W-1:0]      r_den;
    logic [sars_pkg::DEN_W-1:0]      r_rem;
    logic [sars_pkg::NUM_W-1:0]      r_quo;
    logic [sars_pkg::CNT_W-1:0]      r_cnt;

    // output register
    logic                            r_out_valid;
    logic [sars_pkg::INTERVAL_W-1:0] r_o_interval;
    logic [sars_pkg::SPEED_W-1:0]    r_o_speed;
    logic                            r_o_dir;
    logic                            r_o_stopped;
    logic [sars_pkg::RAMP_W-1:0]     r_o_ramp;

    // shift-add multiply step, multiplier MSB first
    logic [sars_pkg::SQ_W-1:0] w_mul_nx;
    assign w_mul_nx = {r_acc[sars_pkg::SQ_W-2:0], 1'b0}
                    + (r_mplr[sars_pkg::SPEED_W-1]
                       ? {{sars_pkg::SPEED_W{1'b0}}, r_speed}
                       : {sars_pkg::SQ_W{1'b0}});

    // restoring divide step, one quotient bit per cycle
    logic [sars_pkg::DEN_W:0]   w_rem_ext;
    logic [sars_pkg::DEN_W+1:0] w_diff;
    logic                       w_qbit;
    logic [sars_pkg::DEN_W-1:0] w_rem_nx;
    assign w_rem_ext = {r_rem, r_num[sars_pkg::NUM_W-1]};
    assign w_diff    = {1'b0, w_rem_ext} - {2'b00, r_den};
    assign w_qbit    = ~w_diff[sars_pkg::DEN_W+1];
    assign w_rem_nx  = w_qbit ? w_diff[sars_pkg::DEN_W-1:0]
                              : w_rem_ext[sars_pkg::DEN_W-1:0];

    // divisor for the stop count; zero acceleration acts as one
    logic [sars_pkg::ACCEL_W-1:0] w_accel_div;
    assign w_accel_div = (r_accel == '0) ? sars_pkg::ACCEL_RST : r_accel;

    // accel/decel decision once stop steps are known
    logic [30:0]                 w_sts;
    logic                        w_d_zero;
    logic [sars_pkg::RAMP_W-1:0] w_ad;
    logic                        w_sts_ge_ad;
    logic                        w_want_cw;
    logic                        w_dir_diff;
    logic                        w_stop;
    logic                        w_ramp_pos;
    logic [sars_pkg::RAMP_W-1:0] n_ramp_dec;

    assign w_sts       = r_quo[30:0];
    assign w_d_zero    = (r_d == '0);
    assign w_ad        = r_d[sars_pkg::RAMP_W-1] ? (~r_d + 32'd1) : r_d;
    assign w_sts_ge_ad = ({1'b0, w_sts} >= w_ad);
    assign w_want_cw   = !r_d[sars_pkg::RAMP_W-1] && !w_d_zero;
    assign w_dir_diff  = (r_dir != w_want_cw);
    assign w_stop      = w_d_zero && (w_sts <= 31'd1);
    assign w_ramp_pos  = !r_ramp[sars_pkg::RAMP_W-1] && (r_ramp != '0);

    always_comb begin
        n_ramp_dec = r_ramp;
        if (!w_d_zero) begin
            if (w_ramp_pos) begin
                if (w_sts_ge_ad || w_dir_diff) begin
                    n_ramp_dec = ~{1'b0, w_sts} + 32'd1;
                end
            end else if (r_ramp[sars_pkg::RAMP_W-1]) begin
                if (!w_sts_ge_ad && !w_dir_diff) begin
                    n_ramp_dec = (r_ramp == sars_pkg::RAMP_MIN) ? sars_pkg::RAMP_MAX
                                                                : (~r_ramp + 32'd1);
                end
            end
        end
    end

    // divisor |4n+1| for the interval recurrence
    logic [sars_pkg::RAMP_W-1:0] w_abs_n;
    logic [sars_pkg::DEN_W:0]    w_mag_neg;
    logic [sars_pkg::DEN_W-1:0]  w_mag;
    assign w_abs_n   = r_ramp[sars_pkg::RAMP_W-1] ? (~r_ramp + 32'd1) : r_ramp;
    assign w_mag_neg = {w_abs_n, 2'b00} - 34'd1;
    assign w_mag     = r_ramp[sars_pkg::RAMP_W-1] ? w_mag_neg[sars_pkg::DEN_W-1:0]
                                                  : {r_ramp[30:0], 2'b01};

    // apply the quotient: shrink while accelerating, grow while decelerating
    logic [sars_pkg::DEN_W-1:0]      w_q;
    logic [sars_pkg::DEN_W-1:0]      w_sub;
    logic [sars_pkg::DEN_W:0]        w_add;
    logic [sars_pkg::INTERVAL_W-1:0] w_sum_sat;
    logic [sars_pkg::INTERVAL_W-1:0] w_r;
    logic [sars_pkg::INTERVAL_W-1:0] n_interval_step;
    logic [sars_pkg::RAMP_W-1:0]     n_ramp_inc;

    assign w_q       = r_quo[sars_pkg::DEN_W-1:0];
    assign w_sub     = ({1'b0, r_interval} >= w_q) ? ({1'b0, r_interval} - w_q) : '0;
    assign w_add     = {2'b00, r_interval} + {1'b0, w_q};
    assign w_sum_sat = (|w_add[sars_pkg::DEN_W:sars_pkg::INTERVAL_W])
                       ? {sars_pkg::INTERVAL_W{1'b1}}
                       : w_add[sars_pkg::INTERVAL_W-1:0];
    assign w_r       = r_ramp[sars_pkg::RAMP_W-1] ? w_sum_sat
                                                  : w_sub[sars_pkg::INTERVAL_W-1:0];
    assign n_interval_step = (w_r < r_min_interval) ? r_min_interval : w_r;
    assign n_ramp_inc = (r_ramp == sars_pkg::RAMP_MAX) ? sars_pkg::RAMP_MAX
                                                       : (r_ramp + 32'd1);

    // speed quotient saturates to 24 bits
    logic [sars_pkg::SPEED_W-1:0] n_speed;
    assign n_speed = (|r_quo[sars_pkg::NUM_W-1:sars_pkg::SPEED_W])
                     ? sars_pkg::SPEED_MAX : r_quo[sars_pkg::SPEED_W-1:0];

    // engine, state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= ST_IDLE;
            r_min_interval   <= sars_pkg::MIN_INTERVAL_RST;
            r_first_interval <= sars_pkg::FIRST_INTERVAL_RST;
            r_accel          <= sars_pkg::ACCEL_RST;
            r_ramp           <= '0;
            r_interval       <= sars_pkg::FIRST_INTERVAL_RST;
            r_speed          <= '0;
            r_dir            <= 1'b0;
            r_stopped        <= 1'b0;
            r_out_valid      <= 1'b0;
            r_cnt            <= '0;
        end else begin
            // config writes, taken while idle
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    sars_pkg::CFG_MIN_INTERVAL:   r_min_interval   <= i_cfg_data;
                    sars_pkg::CFG_FIRST_INTERVAL: r_first_interval <= i_cfg_data;
                    sars_pkg::CFG_ACCEL:
                        r_accel <= i_cfg_data[sars_pkg::ACCEL_W-1:0];
                    default: ;
                endcase
            end

            // result taken; a finishing word refills the register below instead
            if (r_out_valid && !i_out_stall && (r_state != ST_FINISH)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_d       <= i_distance_to_go;
                        r_acc     <= '0;
                        r_mplr    <= r_speed;
                        r_cnt     <= sars_pkg::MUL_BITS;
                        r_stopped <= 1'b0;
                        r_state   <= ST_MUL;
                    end
                end

                ST_MUL: begin
                    if (r_cnt != '0) begin
                        r_acc  <= w_mul_nx;
                        r_mplr <= {r_mplr[sars_pkg::SPEED_W-2:0], 1'b0};
                        r_cnt  <= r_cnt - 6'd1;
                    end else begin
                        // speed^2 >> 17, left aligned in the dividend
                        r_num   <= {r_acc[sars_pkg::SQ_W-1:17], 5'b00000};
                        r_den   <= {{(sars_pkg::DEN_W-sars_pkg::ACCEL_W){1'b0}},
                                    w_accel_div};
                        r_rem   <= '0;
                        r_quo   <= '0;
                        r_cnt   <= sars_pkg::STOP_BITS;
                        r_state <= ST_DIV_STOP;
                    end
                end

                ST_DIV_STOP: begin
                    if (r_cnt != '0) begin
                        r_rem <= w_rem_nx;
                        r_num <= {r_num[sars_pkg::NUM_W-2:0], 1'b0};
                        r_quo <= {r_quo[sars_pkg::NUM_W-2:0], w_qbit};
                        r_cnt <= r_cnt - 6'd1;
                    end else if (w_stop) begin
                        r_ramp    <= '0;
                        r_speed   <= '0;
                        r_stopped <= 1'b1;
                        r_state   <= ST_FINISH;
                    end else if (n_ramp_dec == '0) begin
                        // start from rest
                        r_ramp     <= 32'd1;
                        r_interval <= r_first_interval;
                        r_dir      <= w_want_cw;
                        r_num      <= sars_pkg::SPEED_NUM;
                        r_den      <= {1'b0, r_first_interval};
                        r_rem      <= '0;
                        r_quo      <= '0;
                        r_cnt      <= sars_pkg::SPEED_BITS;
                        r_state    <= ST_DIV_SPEED;
                    end else begin
                        r_ramp  <= n_ramp_dec;
                        r_state <= ST_STEP_LOAD;
                    end
                end

                ST_STEP_LOAD: begin
                    // dividend 2c, divisor |4n+1|
                    r_num   <= {r_interval, 1'b0, 3'b000};
                    r_den   <= w_mag;
                    r_rem   <= '0;
                    r_quo   <= '0;
                    r_cnt   <= sars_pkg::STEP_BITS;
                    r_state <= ST_DIV_STEP;
                end

                ST_DIV_STEP: begin
                    if (r_cnt != '0) begin
                        r_rem <= w_rem_nx;
                        r_num <= {r_num[sars_pkg::NUM_W-2:0], 1'b0};
                        r_quo <= {r_quo[sars_pkg::NUM_W-2:0], w_qbit};
                        r_cnt <= r_cnt - 6'd1;
                    end else begin
                        r_interval <= n_interval_step;
                        r_ramp     <= n_ramp_inc;
                        r_num      <= sars_pkg::SPEED_NUM;
                        r_den      <= {1'b0, n_interval_step};
                        r_rem      <= '0;
                        r_quo      <= '0;
                        r_cnt      <= sars_pkg::SPEED_BITS;
                        r_state    <= ST_DIV_SPEED;
                    end
                end

                ST_DIV_SPEED: begin
                    // a zero interval divides to all ones, which saturates
                    if (r_cnt != '0) begin
                        r_rem <= w_rem_nx;
                        r_num <= {r_num[sars_pkg::NUM_W-2:0], 1'b0};
                        r_quo <= {r_quo[sars_pkg::NUM_W-2:0], w_qbit};
                        r_cnt <= r_cnt - 6'd1;
                    end else begin
                        r_speed <= n_speed;
                        r_state <= ST_FINISH;
                    end
                end

                ST_FINISH: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid  <= 1'b1;
                        r_o_interval <= r_stopped ? '0 : r_interval;
                        r_o_speed    <= r_speed;
                        r_o_dir      <= r_dir;
                        r_o_stopped  <= r_stopped;
                        r_o_ramp     <= r_ramp;
                        r_state      <= ST_IDLE;
                    end
                end

                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_in_stall    = (r_state != ST_IDLE);
    assign o_cfg_ready   = (r_state == ST_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_interval_q8 = r_o_interval;
    assign o_speed_q8    = r_o_speed;
    assign o_move_cw     = r_o_dir;
    assign o_stopped     = r_o_stopped;
    assign o_ramp_index  = r_o_ramp;

endmodule
`default_nettype wire

// File: dv/tb_top.sv
// Self-checking bench for the stepper ramp step block: motion-profile stimulus, checked words.
`timescale 1ns / 1ps
module tb_top;

    // Ramp state, register copy and one result word as the bench models them
    typedef struct {
        logic signed [sars_pkg::RAMP_W-1:0] ramp;
        logic [sars_pkg::INTERVAL_W-1:0]    iv;
        logic [sars_pkg::SPEED_W-1:0]       spd;
        logic                               dir;
    } t_ramp_state;

    typedef struct {
        logic [sars_pkg::INTERVAL_W-1:0] min_iv;
        logic [sars_pkg::INTERVAL_W-1:0] first_iv;
        logic [sars_pkg::ACCEL_W-1:0]    accel;
    } t_ramp_cfg;

    typedef struct {
        logic [sars_pkg::INTERVAL_W-1:0]    iv;
        logic [sars_pkg::SPEED_W-1:0]       spd;
        logic                               cw;
        logic                               stop;
        logic signed [sars_pkg::RAMP_W-1:0] ramp;
    } t_ramp_word;

    logic                                i_clk;
    logic                                i_rst_n = 1'b0;
    logic                                i_in_valid = 1'b0;
    logic                                o_in_stall;
    logic signed [sars_pkg::RAMP_W-1:0]  i_distance_to_go = '0;
    logic                                o_out_valid;
    logic                                i_out_stall = 1'b0;
    logic [sars_pkg::INTERVAL_W-1:0]     o_interval_q8;
    logic [sars_pkg::SPEED_W-1:0]        o_speed_q8;
    logic                                o_move_cw;
    logic                                o_stopped;
    logic signed [sars_pkg::RAMP_W-1:0]  o_ramp_index;
    logic                                i_cfg_valid = 1'b0;
    logic                                o_cfg_ready;
    sars_pkg::t_cfg_idx                  i_cfg_index = sars_pkg::CFG_MIN_INTERVAL;
    logic [sars_pkg::INTERVAL_W-1:0]     i_cfg_data = '0;

    stepper_accel_ramp_step u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_distance_to_go (i_distance_to_go),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_interval_q8    (o_interval_q8),
        .o_speed_q8       (o_speed_q8),
        .o_move_cw        (o_move_cw),
        .o_stopped        (o_stopped),
        .o_ramp_index     (o_ramp_index),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    // Pending step events, expected words, two copies of the ramp (live and planning)
    logic signed [sars_pkg::RAMP_W-1:0] pending_dist[$];
    t_ramp_word               due_words[$];
    t_ramp_state              live_st, plan_st;
    t_ramp_cfg                live_cfg, plan_cfg;
    t_ramp_word               due;
    logic                     plan_stopped = 1'b1;
    int                       plan_left;
    int                       errs = 0;
    int                       words_checked = 0;
    int                       stops_seen = 0;
    int                       settings_used = 0;
    logic                     in_fire = 1'b0;
    logic                     cfg_fire = 1'b0;
    bit                       idle_on = 1'b1;
    bit                       hold_req = 1'b0;
    bit                       hold_done = 1'b0;
    int                       gap_left = 0;
    int                       stall_left = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // One step event: stop check, ramp direction choice, interval recurrence, speed
    function automatic t_ramp_word advance_ramp(inout t_ramp_state st, input t_ramp_cfg cfg,
                                                input logic signed [sars_pkg::RAMP_W-1:0] step_dist);
        longint     d, ad, sts, n, den;
        logic [63:0] a64, quo, c64, r64, mag;
        logic        want_cw;
        t_ramp_word  w;
        d = step_dist;
        ad = (d < 0) ? -d : d;
        n = st.ramp;
        // steps to stop, zero acceleration counts as one
        a64 = (cfg.accel == '0) ? 64'd1 : 64'(cfg.accel);
        quo = (64'(st.spd) * 64'(st.spd)) / (64'd131072 * a64);
        sts = (quo > 64'(sars_pkg::RAMP_MAX)) ? longint'(sars_pkg::RAMP_MAX) : longint'(quo);
        w.stop = 1'b0;
        if (d == 0 && sts <= 1) begin
            n = 0;
            st.spd = '0;
            w.stop = 1'b1;
        end else begin
            if (d != 0) begin
                want_cw = (d > 0);
                if (n > 0) begin
                    if (sts >= ad || st.dir != want_cw) n = -sts;
                end else if (n < 0) begin
                    if (sts < ad && st.dir == want_cw)
                        n = (-n > longint'(sars_pkg::RAMP_MAX)) ?
                            longint'(sars_pkg::RAMP_MAX) : -n;
                end
            end
            if (n == 0) begin
                st.iv = cfg.first_iv;
                st.dir = (d > 0);
            end else begin
                // c' = c -/+ 2c/|4n+1|, held within 32 bits and above the floor
                den = 4 * n + 1;
                mag = (den < 0) ? -den : den;
                c64 = 64'(st.iv);
                quo = (c64 << 1) / mag;
                if (n > 0) r64 = c64 - ((quo > c64) ? c64 : quo);
                else       r64 = c64 + quo;
                if (r64 > 64'hFFFF_FFFF) r64 = 64'hFFFF_FFFF;
                if (r64 < 64'(cfg.min_iv)) r64 = 64'(cfg.min_iv);
                st.iv = r64[31:0];
            end
            n = (n + 1 > longint'(sars_pkg::RAMP_MAX)) ? longint'(sars_pkg::RAMP_MAX) : n + 1;
            if (st.iv == '0) begin
                st.spd = sars_pkg::SPEED_MAX;
            end else begin
                r64 = 64'(sars_pkg::SPEED_NUM) / 64'(st.iv);
                st.spd = (r64 > 64'(sars_pkg::SPEED_MAX)) ? sars_pkg::SPEED_MAX
                                                          : r64[sars_pkg::SPEED_W-1:0];
            end
        end
        st.ramp = n[31:0];
        w.iv   = w.stop ? '0 : st.iv;
        w.spd  = w.stop ? '0 : st.spd;
        w.cw   = st.dir;
        w.ramp = st.ramp;
        return w;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            errs++;
        end
    endfunction

    // Most gaps short, a few long; none while idling is off
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 24);
        return $urandom_range(60, 200);
    endfunction

    // Sampling: handshakes, register copy, prediction on accept, word check
    always @(posedge i_clk) begin
        in_fire  <= i_rst_n && i_in_valid && !o_in_stall;
        cfg_fire <= i_rst_n && i_cfg_valid && o_cfg_ready;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    sars_pkg::CFG_MIN_INTERVAL:   live_cfg.min_iv   = i_cfg_data;
                    sars_pkg::CFG_FIRST_INTERVAL: live_cfg.first_iv = i_cfg_data;
                    sars_pkg::CFG_ACCEL:
                        live_cfg.accel = i_cfg_data[sars_pkg::ACCEL_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !o_in_stall)
                due_words.push_back(advance_ramp(live_st, live_cfg, i_distance_to_go));
            if (o_out_valid && !i_out_stall) begin
                if (due_words.size() == 0) begin
                    $error("result word with nothing expected");
                    errs++;
                end else begin
                    due = due_words.pop_front();
                    check_field("interval_q8", due.iv, o_interval_q8);
                    check_field("speed_q8", 32'(due.spd), 32'(o_speed_q8));
                    check_field("move_cw", 32'(due.cw), 32'(o_move_cw));
                    check_field("stopped", 32'(due.stop), 32'(o_stopped));
                    check_field("ramp_index", due.ramp, o_ramp_index);
                    words_checked++;
                    if (due.stop) stops_seen++;
                end
            end
        end
    end

    // Input driver: next word after a gap once the current one is taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_fire) begin
            if (gap_left > 0) begin
                i_in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (pending_dist.size() > 0) begin
                i_in_valid <= 1'b1;
                i_distance_to_go <= pending_dist.pop_front();
                gap_left <= pick_gap();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Result side stall, with one long hold-off on request
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_done <= 1'b1;
            stall_left <= 400;
            i_out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
            if ($urandom_range(0, 3) == 0) stall_left <= pick_gap();
        end
    end

    task automatic queue_step(input logic signed [sars_pkg::RAMP_W-1:0] step_dist);
        t_ramp_word w;
        w = advance_ramp(plan_st, plan_cfg, step_dist);
        pending_dist.push_back(step_dist);
        plan_stopped = w.stop;
        plan_left--;
    endtask

    // Zero distance until the motor reports a stop, bounded
    task automatic settle();
        int k;
        k = 0;
        while (!plan_stopped && k < 40) begin
            queue_step(0);
            k++;
        end
    endtask

    task automatic wait_idle();
        while (pending_dist.size() != 0 || i_in_valid || due_words.size() != 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(input sars_pkg::t_cfg_idx idx,
                             input logic [sars_pkg::INTERVAL_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(negedge i_clk); while (!cfg_fire);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_regs(input logic [31:0] min_iv, input logic [31:0] first_iv,
                            input logic [19:0] accel);
        wait_idle();
        write_reg(sars_pkg::CFG_MIN_INTERVAL, min_iv);
        write_reg(sars_pkg::CFG_FIRST_INTERVAL, first_iv);
        write_reg(sars_pkg::CFG_ACCEL, 32'(accel));
        plan_cfg.min_iv   = min_iv;
        plan_cfg.first_iv = first_iv;
        plan_cfg.accel    = accel;
        settings_used++;
    endtask

    // Mostly point-to-point moves counting down to zero, some retargets and noise
    task automatic run_moves(input int n_items);
        int   dmag;
        logic neg;
        plan_left = n_items;
        while (plan_left > 0) begin
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 4)) queue_step($urandom());
            end else begin
                dmag = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 400)
                                                   : $urandom_range(1, 60);
                neg = $urandom_range(0, 1);
                while (dmag > 0 && plan_left > 0) begin
                    queue_step(neg ? -dmag : dmag);
                    if ($urandom_range(0, 39) == 0) begin
                        dmag = $urandom_range(1, 100);
                        neg = $urandom_range(0, 1);
                    end else begin
                        dmag--;
                    end
                end
                settle();
            end
        end
    endtask

    // Time limit
    initial begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

    logic [31:0] ph_min[6], ph_first[6];
    logic [19:0] ph_acc[6];

    initial begin
        live_cfg.min_iv   = sars_pkg::MIN_INTERVAL_RST;
        live_cfg.first_iv = sars_pkg::FIRST_INTERVAL_RST;
        live_cfg.accel    = sars_pkg::ACCEL_RST;
        live_st.ramp = '0;
        live_st.iv   = sars_pkg::FIRST_INTERVAL_RST;
        live_st.spd  = '0;
        live_st.dir  = 1'b0;
        plan_cfg = live_cfg;
        plan_st  = live_st;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Stop at rest under reset settings
        queue_step(0);
        queue_step(0);

        // Reversal at one stop step leaves the ramp at zero while still moving
        set_regs(32'd256, 32'd163840, 20'hFFFFF);
        queue_step(10);
        queue_step(-10);
        // Slowest acceleration: zero-distance step from ramp zero goes anticlockwise
        set_regs(32'd256, 32'd163840, 20'd1);
        queue_step(0);
        queue_step(0);
        // Decelerate and come to rest
        set_regs(32'd256, 32'd163840, 20'hFFFFF);
        queue_step(0);
        queue_step(-1);
        settle();
        // Zero acceleration, zero interval, extreme distances and ramp counts
        set_regs(32'd0, 32'd0, 20'd0);
        queue_step(1);
        queue_step(1);
        queue_step(32'sh7FFF_FFFF);
        queue_step(32'sh8000_0000);
        queue_step(0);
        queue_step(-1);

        // Random phases
        ph_min[0] = 32'd128000;     ph_first[0] = 32'd7739392;     ph_acc[0] = 20'd1000;
        ph_min[1] = 32'd25600;      ph_first[1] = 32'd1730560;     ph_acc[1] = 20'd20000;
        ph_min[2] = 32'd256;        ph_first[2] = 32'd256;         ph_acc[2] = 20'hFFFFF;
        ph_min[3] = 32'hFFFF_FFFF;  ph_first[3] = 32'hFFFF_FFFF;   ph_acc[3] = 20'd1;
        ph_min[4] = $urandom_range(256, 400000);
        ph_first[4] = $urandom_range(256, 20000000);
        ph_acc[4] = $urandom_range(1, 1048575);
        ph_min[5] = $urandom_range(256, 40000);
        ph_first[5] = $urandom_range(500000, 9000000);
        ph_acc[5] = $urandom_range(100, 50000);
        for (int p = 0; p < 6; p++) begin
            set_regs(ph_min[p], ph_first[p], ph_acc[p]);
            idle_on = (p != 1);
            if (p == 2) hold_req = 1'b1;
            run_moves(320);
        end

        wait_idle();
        repeat (200) @(negedge i_clk);
        if (due_words.size() != 0) begin
            $error("%0d expected words never arrived", due_words.size());
            errs++;
        end
        $display("Checked %0d ramp words (%0d stops) across %0d register settings,",
                 words_checked, stops_seen, settings_used);
        $display("with directed extremes, random moves, retargets and noise distances.");
        if (errs == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
